>>> rtl/mpv_pkg.sv
// ----------------------------------------------------------------------------
// mpv_pkg
// Shared types and constants of the moving population variance unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mpv_pkg;

  // defaults for the top-level parameters
  localparam int MAX_WINDOW_DEF    = 256;
  localparam int SAMPLE_BITS_DEF   = 24;
  localparam int FRACTION_BITS_DEF = 8;

  // fixed field widths of the channels
  localparam int SAMPLE_W = 24;
  localparam int VAR_W    = 56;
  localparam int COUNT_W  = 9;

  // window register
  localparam int                 WINDOW_MIN   = 2;
  localparam logic [COUNT_W-1:0] WINDOW_RESET = 9'd10;

  // configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-3:0] REG_WINDOW = '0;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       new_series;
  } in_item_t;

  typedef struct packed {
    logic [VAR_W-1:0]   variance;
    logic [COUNT_W-1:0] samples_in_window;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OLD,
    ST_NEW,
    ST_ACC,
    ST_MULC,
    ST_MULS,
    ST_DPREP,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

>>> rtl/mpv_ram.sv
// ----------------------------------------------------------------------------
// mpv_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mpv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/mpv_alu.sv
// ----------------------------------------------------------------------------
// mpv_alu
// Shared add/subtract unit for the multiply and divide steps.
// ----------------------------------------------------------------------------
`default_nettype none

module mpv_alu #(
  parameter int WIDTH = 16
) (
  input  wire logic [WIDTH-1:0] a,
  input  wire logic [WIDTH-1:0] b,
  input  wire logic             sub,
  output logic      [WIDTH-1:0] res
);

  always_comb begin
    if (sub) begin
      res = a - b;
    end else begin
      res = a + b;
    end
  end

endmodule

`default_nettype wire

>>> rtl/moving_population_variance_unit.sv
// ----------------------------------------------------------------------------
// moving_population_variance_unit
// Sliding-window population variance of signed samples, fixed point result.
// ----------------------------------------------------------------------------
// the shared adder runs both multiplies and the restoring divide one bit per cycle
//   between the input transfer and out_valid; the result waits in the done state
//   while the output register still holds a result that has not been taken
// in_ready is high only when idle, so a new input is taken only after the result is written
// a result held in the output register does not block the next input transfer
// reset: sums, count, pointer and reference cleared, window_length = 10;
//   the history memory is not cleared
`default_nettype none

module moving_population_variance_unit #(
  parameter int MAX_WINDOW    = mpv_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS   = mpv_pkg::SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = mpv_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire mpv_pkg::in_item_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output mpv_pkg::out_item_t                     out_data,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [mpv_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [mpv_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic      [mpv_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                   pready
);

  localparam int LOG_W  = $clog2(MAX_WINDOW);
  localparam int AW     = LOG_W;
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int SB     = SAMPLE_BITS;
  localparam int D_W    = SB + 1;
  localparam int SQ_W   = 2 * SB + LOG_W;
  localparam int MAG_W  = SB + LOG_W;
  localparam int SUM_W  = MAG_W + 1;
  localparam int NUM_W  = 2 * MAG_W;
  localparam int ACC_W  = NUM_W + 1;
  localparam int DEN_W  = 2 * CNT_W;
  localparam int VAR_W  = mpv_pkg::VAR_W;
  localparam int DVX_W  = (NUM_W + FRACTION_BITS > VAR_W) ? NUM_W + FRACTION_BITS : VAR_W + 1;
  localparam int TOP_W  = DVX_W - VAR_W;
  localparam int CMP_W  = (TOP_W > DEN_W) ? TOP_W : DEN_W;
  localparam int STEP_N = (VAR_W > MAG_W) ? VAR_W : MAG_W;
  localparam int STEP_W = $clog2(STEP_N);
  localparam int PW     = CNT_W + 1;

  mpv_pkg::state_t state_r, state_nxt;

  logic [mpv_pkg::COUNT_W-1:0] window_r, window_nxt;
  logic signed [SB-1:0]        ref_r, ref_nxt;
  logic signed [SUM_W-1:0]     sum_r, sum_nxt;
  logic [SQ_W-1:0]             sqs_r, sqs_nxt;
  logic [CNT_W-1:0]            fill_r, fill_nxt;
  logic [AW-1:0]               wp_r, wp_nxt;
  logic                        out_valid_r, out_valid_nxt;

  logic signed [D_W-1:0]       d_r, d_nxt;
  logic                        evict_r, evict_nxt;
  logic [2*SB-1:0]             sq_r, sq_nxt;
  logic [ACC_W-1:0]            acc_r, acc_nxt;
  logic [ACC_W-1:0]            mcand_r, mcand_nxt;
  logic [MAG_W-1:0]            mplier_r, mplier_nxt;
  logic [STEP_W-1:0]           step_r, step_nxt;
  logic [DEN_W-1:0]            den_r, den_nxt;
  logic [DEN_W-1:0]            rem_r, rem_nxt;
  logic [VAR_W-1:0]            quo_r, quo_nxt;
  logic                        sat_r, sat_nxt;
  mpv_pkg::out_item_t          out_data_r, out_data_nxt;

  // window clamp and config decode
  logic [CNT_W-1:0] n_c;
  logic             cfg_hit;

  // accept-side values
  logic signed [SB-1:0]  smp;
  logic                  restart;
  logic signed [SB-1:0]  ref_eff;
  logic [CNT_W-1:0]      fill_eff;
  logic signed [D_W-1:0] d_calc;
  logic [PW-1:0]         rd_t;

  // history memory
  logic                  ram_we;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [D_W-1:0]        ram_rdata;

  // magnitudes and squares
  logic signed [D_W-1:0] old_v, old_neg, d_neg;
  logic [SB-1:0]         mag_old, mag_d, mul_in;
  logic [2*SB-1:0]       mul_out;
  logic [SQ_W-1:0]       sqs_add;
  logic signed [SUM_W-1:0] sum_neg;
  logic [MAG_W-1:0]      sum_mag;

  // shared unit
  logic [ACC_W-1:0]      alu_a, alu_b, alu_res;
  logic                  alu_sub;
  logic [DEN_W:0]        trial;
  logic                  trial_ok;

  // divide set-up
  logic [NUM_W-1:0]      num;
  logic [DVX_W-1:0]      dvd;
  logic [CMP_W-1:0]      top_c, den_c;

  always_comb begin
    if (window_r < mpv_pkg::COUNT_W'(mpv_pkg::WINDOW_MIN)) begin
      n_c = CNT_W'(mpv_pkg::WINDOW_MIN);
    end else if (32'(window_r) > 32'(MAX_WINDOW)) begin
      n_c = CNT_W'(MAX_WINDOW);
    end else begin
      n_c = CNT_W'(window_r);
    end
  end

  assign cfg_hit = psel && penable && pwrite
                   && (paddr[mpv_pkg::CFG_ADDR_W-1:2] == mpv_pkg::REG_WINDOW);
  assign pready  = 1'b1;
  assign prdata  = (paddr[mpv_pkg::CFG_ADDR_W-1:2] == mpv_pkg::REG_WINDOW)
                   ? mpv_pkg::CFG_DATA_W'(window_r) : '0;

  assign smp      = in_data.sample[SB-1:0];
  assign restart  = in_data.new_series || (fill_r == '0);
  assign ref_eff  = restart ? smp : ref_r;
  assign fill_eff = restart ? '0 : fill_r;
  assign d_calc   = D_W'(smp) - D_W'(ref_eff);

  // oldest entry of the window, wrapped round the history
  assign rd_t      = PW'(wp_r) + PW'(MAX_WINDOW) - PW'(n_c);
  assign ram_raddr = (rd_t >= PW'(MAX_WINDOW)) ? AW'(rd_t - PW'(MAX_WINDOW)) : AW'(rd_t);

  assign old_v   = evict_r ? ram_rdata : '0;
  assign old_neg = -old_v;
  assign d_neg   = -d_r;
  assign mag_old = old_v[D_W-1] ? old_neg[SB-1:0] : old_v[SB-1:0];
  assign mag_d   = d_r[D_W-1] ? d_neg[SB-1:0] : d_r[SB-1:0];
  assign mul_in  = (state_r == mpv_pkg::ST_OLD) ? mag_old : mag_d;
  assign mul_out = (2*SB)'(mul_in) * (2*SB)'(mul_in);
  assign sqs_add = sqs_r + SQ_W'(sq_r);
  assign sum_neg = -sum_r;
  assign sum_mag = sum_r[SUM_W-1] ? sum_neg[MAG_W-1:0] : sum_r[MAG_W-1:0];

  assign trial = {rem_r, quo_r[VAR_W-1]};

  always_comb begin
    unique case (state_r)
      mpv_pkg::ST_MULS: begin
        alu_a   = acc_r;
        alu_b   = mcand_r;
        alu_sub = 1'b1;
      end
      mpv_pkg::ST_DIV: begin
        alu_a   = ACC_W'(trial);
        alu_b   = ACC_W'(den_r);
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = acc_r;
        alu_b   = mcand_r;
        alu_sub = 1'b0;
      end
    endcase
  end

  mpv_alu #(
    .WIDTH (ACC_W)
  ) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu_res)
  );

  assign trial_ok = !alu_res[ACC_W-1];

  assign num   = acc_r[ACC_W-1] ? '0 : acc_r[NUM_W-1:0];
  assign dvd   = DVX_W'(num) << FRACTION_BITS;
  assign top_c = CMP_W'(dvd[DVX_W-1:VAR_W]);
  assign den_c = CMP_W'(den_r);

  mpv_ram #(
    .WIDTH (D_W),
    .DEPTH (MAX_WINDOW)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (d_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mpv_pkg::ST_IDLE;
      window_r    <= mpv_pkg::WINDOW_RESET;
      ref_r       <= '0;
      sum_r       <= '0;
      sqs_r       <= '0;
      fill_r      <= '0;
      wp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      window_r    <= window_nxt;
      ref_r       <= ref_nxt;
      sum_r       <= sum_nxt;
      sqs_r       <= sqs_nxt;
      fill_r      <= fill_nxt;
      wp_r        <= wp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r        <= d_nxt;
    evict_r    <= evict_nxt;
    sq_r       <= sq_nxt;
    acc_r      <= acc_nxt;
    mcand_r    <= mcand_nxt;
    mplier_r   <= mplier_nxt;
    step_r     <= step_nxt;
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    sat_r      <= sat_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    window_nxt    = window_r;
    ref_nxt       = ref_r;
    sum_nxt       = sum_r;
    sqs_nxt       = sqs_r;
    fill_nxt      = fill_r;
    wp_nxt        = wp_r;
    out_valid_nxt = out_valid_r;
    d_nxt         = d_r;
    evict_nxt     = evict_r;
    sq_nxt        = sq_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    step_nxt      = step_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    sat_nxt       = sat_r;
    out_data_nxt  = out_data_r;
    in_ready      = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      mpv_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ram_re    = 1'b1;
          d_nxt     = d_calc;
          evict_nxt = (fill_eff >= n_c);
          fill_nxt  = (fill_eff >= n_c) ? n_c : CNT_W'(fill_eff + 1'b1);
          if (restart) begin
            ref_nxt = smp;
            sum_nxt = '0;
            sqs_nxt = '0;
          end
          state_nxt = mpv_pkg::ST_OLD;
        end
      end
      mpv_pkg::ST_OLD: begin
        sum_nxt   = sum_r - SUM_W'(old_v);
        sq_nxt    = mul_out;
        state_nxt = mpv_pkg::ST_NEW;
      end
      mpv_pkg::ST_NEW: begin
        sqs_nxt   = sqs_r - SQ_W'(sq_r);
        sq_nxt    = mul_out;
        sum_nxt   = sum_r + SUM_W'(d_r);
        ram_we    = 1'b1;
        wp_nxt    = (wp_r == AW'(MAX_WINDOW - 1)) ? '0 : AW'(wp_r + 1'b1);
        state_nxt = mpv_pkg::ST_ACC;
      end
      mpv_pkg::ST_ACC: begin
        sqs_nxt    = sqs_add;
        acc_nxt    = '0;
        mcand_nxt  = ACC_W'(sqs_add);
        mplier_nxt = MAG_W'(fill_r);
        step_nxt   = '0;
        den_nxt    = DEN_W'(fill_r) * DEN_W'(fill_r);
        state_nxt  = mpv_pkg::ST_MULC;
      end
      mpv_pkg::ST_MULC: begin
        // count times sum of squares, shift-and-add
        if (mplier_r[0]) begin
          acc_nxt = alu_res;
        end
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        step_nxt   = STEP_W'(step_r + 1'b1);
        if (step_r == STEP_W'(CNT_W - 1)) begin
          mcand_nxt  = ACC_W'(sum_mag);
          mplier_nxt = sum_mag;
          step_nxt   = '0;
          state_nxt  = mpv_pkg::ST_MULS;
        end
      end
      mpv_pkg::ST_MULS: begin
        // minus sum squared, shift-and-subtract
        if (mplier_r[0]) begin
          acc_nxt = alu_res;
        end
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        step_nxt   = STEP_W'(step_r + 1'b1);
        if (step_r == STEP_W'(MAG_W - 1)) begin
          step_nxt  = '0;
          state_nxt = mpv_pkg::ST_DPREP;
        end
      end
      mpv_pkg::ST_DPREP: begin
        // upper dividend bits at or above the divisor mean the quotient overflows
        sat_nxt  = (top_c >= den_c);
        rem_nxt  = top_c[DEN_W-1:0];
        quo_nxt  = dvd[VAR_W-1:0];
        step_nxt = '0;
        if (top_c >= den_c) begin
          state_nxt = mpv_pkg::ST_DONE;
        end else begin
          state_nxt = mpv_pkg::ST_DIV;
        end
      end
      mpv_pkg::ST_DIV: begin
        // restoring divide, dividend bits shift out of quo_r as quotient bits enter
        rem_nxt  = trial_ok ? alu_res[DEN_W-1:0] : trial[DEN_W-1:0];
        quo_nxt  = {quo_r[VAR_W-2:0], trial_ok};
        step_nxt = STEP_W'(step_r + 1'b1);
        if (step_r == STEP_W'(VAR_W - 1)) begin
          state_nxt = mpv_pkg::ST_DONE;
        end
      end
      mpv_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.variance          = sat_r ? '1 : quo_r;
          out_data_nxt.samples_in_window = mpv_pkg::COUNT_W'(fill_r);
          out_valid_nxt                  = 1'b1;
          state_nxt                      = mpv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mpv_pkg::ST_IDLE;
      end
    endcase

    // window change restarts the series
    if (cfg_hit) begin
      window_nxt = pwdata[mpv_pkg::COUNT_W-1:0];
      fill_nxt   = '0;
      sum_nxt    = '0;
      sqs_nxt    = '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == mpv_pkg::ST_DONE))
    else $error("result raised outside the done state");

  a_fill_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= n_c)
    else $error("fill count beyond window length");

  a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mpv_pkg::ST_DIV) |-> (rem_r < den_r))
    else $error("divide remainder not below divisor");

  a_no_saturation: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mpv_pkg::ST_DONE) |-> !sat_r)
    else $error("variance overflowed, bounded sample range violated");

endmodule

`default_nettype wire
